FILE: design/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared sizes, opcodes and status codes of the graph search engine.
// ----------------------------------------------------------------------------
package gtr_pkg;

	localparam int VERTEX_MAX = 64;
	localparam int VTX_W      = $clog2(VERTEX_MAX);
	localparam int EDGE_MAX   = 256;
	localparam int EDGE_W     = $clog2(EDGE_MAX);
	localparam int EPTR_W     = EDGE_W + 1;
	localparam int CNT_W      = VTX_W + 1;
	localparam int EREC_W     = VTX_W + EPTR_W;

	localparam logic [EPTR_W-1:0] NO_EDGE = EPTR_W'(EDGE_MAX);

	localparam logic [2:0] OP_ADD_EDGE      = 3'd0;
	localparam logic [2:0] OP_BFS           = 3'd1;
	localparam logic [2:0] OP_DFS           = 3'd2;
	localparam logic [2:0] OP_CLEAR_VISITED = 3'd3;
	localparam logic [2:0] OP_CLEAR_GRAPH   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

endpackage

FILE: design/graph_traversal_bfs_dfs_top.sv
// ----------------------------------------------------------------------------
// graph_traversal_bfs_dfs_top
// Directed graph store with breadth-first and depth-first search.
// ----------------------------------------------------------------------------
// Sequence: clear visited, clear graph and a rejected add edge put their one
// result item into the hold register when the item is accepted, a stored
// edge in S_ADD_WR; S_FIN then moves it to the output register, waiting
// while the result output is stalled. The next item is taken after S_FIN. A
// BFS steps through S_B_POP, S_B_HEAD and S_B_EDGE0 per dequeued vertex and
// S_B_EDGE per examined edge, a DFS through S_D_TOP and S_D_EDGE per examined
// edge, both bounded by the single read port of the edge memory.
// One item is processed at a time.
// Reset: asynchronous, clears the graph, the visited marks and vertex_count
// at once through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module graph_traversal_bfs_dfs_top
	import gtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] from_vertex, [11:6] to_vertex, zero pad
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	// Result item stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] visit_vertex, zero pad
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,   // last_of_run
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_WR, S_FIN,
		S_B_POP, S_B_HEAD, S_B_EDGE0, S_B_EDGE,
		S_D_PUSH, S_D_TOP, S_D_EDGE, S_D_RELOAD
	} state_t;

	state_t state_q, state_d;

	// Configuration register.
	logic [CNT_W-1:0] vc_q;
	logic [CNT_W-1:0] vcnt;

	// Small control state: valid bits of the head memory and visited marks.
	logic [VERTEX_MAX-1:0] head_vld_q, head_vld_d;
	logic [VERTEX_MAX-1:0] visited_q, visited_d;
	logic [EPTR_W-1:0]     edges_used_q, edges_used_d;

	// Traversal registers. cnt_q is the queue write position in BFS and the
	// stack depth in DFS; the top of the DFS stack lives in top_q.
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  rp_q, rp_d;
	logic [EPTR_W-1:0] top_q, top_d;
	logic [VTX_W-1:0]  vtx_q, vtx_d;
	logic [VTX_W-1:0]  from_q, from_d;
	logic [VTX_W-1:0]  to_q, to_d;

	// Result path: a hold register keeps the newest result until we know
	// whether it is the last of its run, then it moves to the output register.
	logic             hold_vld_q;
	logic [VTX_W-1:0] hold_vertex_q;
	logic [1:0]       hold_status_q;
	logic             out_vld_q;
	logic [VTX_W-1:0] out_vertex_q;
	logic [1:0]       out_status_q;
	logic             out_last_q;
	logic             out_free, can_emit;
	logic             emit_en, fin_en;
	logic [VTX_W-1:0] emit_vertex;
	logic [1:0]       emit_status;

	// Memory ports.
	logic              head_we, head_re;
	logic [VTX_W-1:0]  head_waddr, head_raddr;
	logic [EDGE_W-1:0] head_wdata, head_rd;
	logic              edge_we, edge_re;
	logic [EDGE_W-1:0] edge_waddr, edge_raddr;
	logic [EREC_W-1:0] edge_wdata, edge_rd;
	logic              work_we, work_re;
	logic [VTX_W-1:0]  work_waddr, work_raddr;
	logic [EPTR_W-1:0] work_wdata, work_rd;

	logic [2:0]        in_op;
	logic [VTX_W-1:0]  in_from, in_to;
	logic [VTX_W-1:0]  tgt;
	logic [EPTR_W-1:0] nxt;
	logic              tgt_new;

	assign in_op   = s_tuser;
	assign in_from = s_tdata[VTX_W-1:0];
	assign in_to   = s_tdata[2*VTX_W-1:VTX_W];
	assign tgt     = edge_rd[VTX_W-1:0];
	assign nxt     = edge_rd[EREC_W-1:VTX_W];
	assign tgt_new = !visited_q[tgt];

	assign vcnt     = (vc_q > CNT_W'(VERTEX_MAX)) ? CNT_W'(VERTEX_MAX) : vc_q;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || m_tready;
	assign can_emit = !hold_vld_q || out_free;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_vertex_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_VERTEX_COUNT) ? {25'd0, vc_q} : 32'd0;

	// The per-item sequencer: every memory access and state update is decided
	// here; the clocked block below only registers the results.
	always_comb begin
		state_d      = state_q;
		head_vld_d   = head_vld_q;
		visited_d    = visited_q;
		edges_used_d = edges_used_q;
		cnt_d        = cnt_q;
		rp_d         = rp_q;
		top_d        = top_q;
		vtx_d        = vtx_q;
		from_d       = from_q;
		to_d         = to_q;
		emit_en      = 1'b0;
		emit_vertex  = '0;
		emit_status  = ST_OK;
		fin_en       = 1'b0;
		head_we      = 1'b0;
		head_waddr   = from_q;
		head_wdata   = edges_used_q[EDGE_W-1:0];
		head_re      = 1'b0;
		head_raddr   = in_from;
		edge_we      = 1'b0;
		edge_waddr   = edges_used_q[EDGE_W-1:0];
		edge_wdata   = '0;
		edge_re      = 1'b0;
		edge_raddr   = top_q[EDGE_W-1:0];
		work_we      = 1'b0;
		work_waddr   = '0;
		work_wdata   = '0;
		work_re      = 1'b0;
		work_raddr   = rp_q[VTX_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					from_d = in_from;
					to_d   = in_to;
					case (in_op)
						OP_ADD_EDGE: begin
							if ({1'b0, in_from} >= vcnt || {1'b0, in_to} >= vcnt) begin
								emit_en     = 1'b1;
								emit_status = ST_RANGE;
								state_d     = S_FIN;
							end else if (edges_used_q[EDGE_W]) begin
								emit_en     = 1'b1;
								emit_status = ST_FULL;
								state_d     = S_FIN;
							end else begin
								head_re    = 1'b1;
								head_raddr = in_from;
								state_d    = S_ADD_WR;
							end
						end
						OP_BFS: begin
							emit_en            = 1'b1;
							emit_vertex        = in_from;
							visited_d[in_from] = 1'b1;
							work_we            = 1'b1;
							work_waddr         = '0;
							work_wdata         = EPTR_W'(in_from);
							cnt_d              = CNT_W'(1);
							rp_d               = '0;
							state_d            = S_B_POP;
						end
						OP_DFS: begin
							emit_en            = 1'b1;
							emit_vertex        = in_from;
							visited_d[in_from] = 1'b1;
							head_re            = 1'b1;
							head_raddr         = in_from;
							vtx_d              = in_from;
							cnt_d              = '0;
							state_d            = S_D_PUSH;
						end
						OP_CLEAR_VISITED: begin
							visited_d = '0;
							emit_en   = 1'b1;
							state_d   = S_FIN;
						end
						OP_CLEAR_GRAPH: begin
							head_vld_d   = '0;
							edges_used_d = '0;
							emit_en      = 1'b1;
							state_d      = S_FIN;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ADD_WR: begin
				edge_we            = 1'b1;
				edge_wdata         = {(head_vld_q[from_q] ? {1'b0, head_rd} : NO_EDGE), to_q};
				head_we            = 1'b1;
				head_vld_d[from_q] = 1'b1;
				edges_used_d       = edges_used_q + EPTR_W'(1);
				emit_en            = 1'b1;
				state_d            = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					fin_en  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_B_POP: begin
				if (rp_q == cnt_q) begin
					state_d = S_FIN;
				end else begin
					work_re = 1'b1;
					rp_d    = rp_q + CNT_W'(1);
					state_d = S_B_HEAD;
				end
			end
			S_B_HEAD: begin
				head_re    = 1'b1;
				head_raddr = work_rd[VTX_W-1:0];
				vtx_d      = work_rd[VTX_W-1:0];
				state_d    = S_B_EDGE0;
			end
			S_B_EDGE0: begin
				if (!head_vld_q[vtx_q]) begin
					state_d = S_B_POP;
				end else begin
					edge_re    = 1'b1;
					edge_raddr = head_rd;
					state_d    = S_B_EDGE;
				end
			end
			S_B_EDGE: begin
				if (!tgt_new || can_emit) begin
					if (tgt_new) begin
						emit_en        = 1'b1;
						emit_vertex    = tgt;
						visited_d[tgt] = 1'b1;
						if (!cnt_q[CNT_W-1]) begin
							work_we    = 1'b1;
							work_waddr = cnt_q[VTX_W-1:0];
							work_wdata = EPTR_W'(tgt);
							cnt_d      = cnt_q + CNT_W'(1);
						end
					end
					if (nxt[EDGE_W]) begin
						state_d = S_B_POP;
					end else begin
						edge_re    = 1'b1;
						edge_raddr = nxt[EDGE_W-1:0];
					end
				end
			end
			S_D_PUSH: begin
				if (cnt_q != '0) begin
					work_we    = 1'b1;
					work_waddr = VTX_W'(cnt_q - CNT_W'(1));
					work_wdata = top_q;
				end
				top_d   = head_vld_q[vtx_q] ? {1'b0, head_rd} : NO_EDGE;
				cnt_d   = cnt_q + CNT_W'(1);
				state_d = S_D_TOP;
			end
			S_D_TOP: begin
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end else if (top_q[EDGE_W]) begin
					cnt_d = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_d = S_FIN;
					end else begin
						work_re    = 1'b1;
						work_raddr = VTX_W'(cnt_q - CNT_W'(2));
						state_d    = S_D_RELOAD;
					end
				end else begin
					edge_re    = 1'b1;
					edge_raddr = top_q[EDGE_W-1:0];
					state_d    = S_D_EDGE;
				end
			end
			S_D_EDGE: begin
				if (!tgt_new || can_emit) begin
					top_d   = nxt;
					state_d = S_D_TOP;
					if (tgt_new) begin
						emit_en        = 1'b1;
						emit_vertex    = tgt;
						visited_d[tgt] = 1'b1;
						if (!cnt_q[CNT_W-1]) begin
							vtx_d      = tgt;
							head_re    = 1'b1;
							head_raddr = tgt;
							state_d    = S_D_PUSH;
						end
					end
				end
			end
			S_D_RELOAD: begin
				top_d   = work_rd;
				state_d = S_D_TOP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			vc_q          <= '0;
			head_vld_q    <= '0;
			visited_q     <= '0;
			edges_used_q  <= '0;
			cnt_q         <= '0;
			rp_q          <= '0;
			top_q         <= NO_EDGE;
			hold_vld_q    <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_vld_q   <= head_vld_d;
			visited_q    <= visited_d;
			edges_used_q <= edges_used_d;
			cnt_q        <= cnt_d;
			rp_q         <= rp_d;
			top_q        <= top_d;
			if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT) begin
				vc_q <= pwdata[CNT_W-1:0];
			end
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (emit_en) begin
				if (hold_vld_q) begin
					out_vld_q    <= 1'b1;
					out_vertex_q <= hold_vertex_q;
					out_status_q <= hold_status_q;
					out_last_q   <= 1'b0;
				end
				hold_vld_q    <= 1'b1;
				hold_vertex_q <= emit_vertex;
				hold_status_q <= emit_status;
			end
			if (fin_en) begin
				out_vld_q    <= 1'b1;
				out_vertex_q <= hold_vertex_q;
				out_status_q <= hold_status_q;
				out_last_q   <= 1'b1;
				hold_vld_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vtx_q  <= vtx_d;
		from_q <= from_d;
		to_q   <= to_d;
	end

	// List heads, one per vertex; an entry without its valid bit is empty.
	gtr_ram #(.WIDTH(EDGE_W), .DEPTH(VERTEX_MAX)) u_head_ram (
		.clk     (clk),
		.wr_en   (head_we),
		.wr_addr (head_waddr),
		.wr_data (head_wdata),
		.rd_en   (head_re),
		.rd_addr (head_raddr),
		.rd_data (head_rd)
	);

	// Edge records: {next edge pointer, target vertex}.
	gtr_ram #(.WIDTH(EREC_W), .DEPTH(EDGE_MAX)) u_edge_ram (
		.clk     (clk),
		.wr_en   (edge_we),
		.wr_addr (edge_waddr),
		.wr_data (edge_wdata),
		.rd_en   (edge_re),
		.rd_addr (edge_raddr),
		.rd_data (edge_rd)
	);

	// Shared work memory: the BFS queue of vertices or the DFS edge stack.
	gtr_ram #(.WIDTH(EPTR_W), .DEPTH(VERTEX_MAX)) u_work_ram (
		.clk     (clk),
		.wr_en   (work_we),
		.wr_addr (work_waddr),
		.wr_data (work_wdata),
		.rd_en   (work_re),
		.rd_addr (work_raddr),
		.rd_data (work_rd)
	);

endmodule

FILE: design/gtr_ram.sv
// ----------------------------------------------------------------------------
// gtr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/gtr_checker.sv
// ----------------------------------------------------------------------------
// gtr_checker
// Port-level checks of the graph search engine, bound to the top level.
// ----------------------------------------------------------------------------
module gtr_checker
	import gtr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// Error results are lone acknowledgements.
	a_err_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == 8'd0)
		else $error("error result is not a lone acknowledgement");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_RANGE || m_tuser == ST_FULL)
		else $error("unknown status code");

	// A valid operation keeps the engine busy for the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser <= OP_CLEAR_GRAPH |=> !s_tready)
		else $error("engine took a second item while busy");

endmodule

bind graph_traversal_bfs_dfs_top gtr_checker u_gtr_checker (.*);
